>>> sv/directed_loop_probabilities_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for directed_loop_probabilities_top
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef DIRECTED_LOOP_PROBABILITIES_TOP_MACROS_SVH
`define DIRECTED_LOOP_PROBABILITIES_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DLP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dlp: implication check failed");
`define DLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dlp: next-cycle check failed");
`else
`define DLP_ASSERT_IMP(label, ante, cons)
`define DLP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/dlp_pkg.sv
// ---------------------------------------------------------------------------
// dlp_pkg
// Shared widths, types and codes of the directed-loop probability block.
// ---------------------------------------------------------------------------
package dlp_pkg;

    localparam int WEIGHT_BITS    = 32;
    localparam int PROB_FRAC_BITS = 16;
    localparam int IN_BITS        = 32;
    localparam int PROB_W         = 17;
    localparam int LANES          = 4;
    localparam int WB_USE         = (WEIGHT_BITS < IN_BITS) ? WEIGHT_BITS : IN_BITS;
    localparam int DW             = WEIGHT_BITS + 2;
    localparam int QW             = PROB_FRAC_BITS + 1;
    localparam int S_DATA_W       = LANES * IN_BITS;
    localparam int M_DATA_W       = ((2 + LANES * PROB_W + 7) / 8) * 8;

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [DW-1:0]          wide_t;
    typedef logic [1:0]             pos_t;
    typedef logic [QW-1:0]          prob_t;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        kind_t kind;
        wide_t num;
        wide_t den;
    } lane_in_t;

    typedef struct packed {
        pos_t             row_index;
        pos_t [LANES-1:0] col_map;
        logic             deg;
        logic             last;
    } row_meta_t;

endpackage

>>> sv/dlp_front.sv
// ---------------------------------------------------------------------------
// dlp_front
// Row sequencer, stable ranking, regime sums and per-row lane setup.
// ---------------------------------------------------------------------------
module dlp_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dlp_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            row_valid,
    output dlp_pkg::row_meta_t              row_meta,
    output dlp_pkg::lane_in_t [dlp_pkg::LANES-1:0] lane_in
);

    dlp_pkg::weight_t [3:0] w_reg;
    logic                   busy_reg;
    dlp_pkg::pos_t          row_reg;

    dlp_pkg::pos_t   [3:0] rank;
    dlp_pkg::pos_t   [3:0] idx;
    dlp_pkg::weight_t [3:0] sorted;
    logic            [2:0] cnt;

    logic                   p1_valid_reg;
    dlp_pkg::weight_t [3:0] p1_w_reg;
    dlp_pkg::pos_t   [3:0]  p1_idx_reg;
    dlp_pkg::pos_t          p1_pos_reg;
    dlp_pkg::pos_t          p1_row_reg;

    logic                   p2_valid_reg;
    dlp_pkg::wide_t         p2_a_reg, p2_b_reg, p2_c_reg, p2_d_reg;
    dlp_pkg::wide_t         p2_abcd_reg, p2_pab_reg, p2_pac_reg, p2_pbc_reg;
    logic                   p2_bounce_reg;
    dlp_pkg::pos_t   [3:0]  p2_idx_reg;
    dlp_pkg::pos_t          p2_pos_reg;
    dlp_pkg::pos_t          p2_row_reg;

    dlp_pkg::wide_t         wa, wb, wc, wd, sum_bcd;

    logic                   p3_valid_reg;
    dlp_pkg::row_meta_t     p3_meta_reg;
    dlp_pkg::lane_in_t [dlp_pkg::LANES-1:0] p3_lane_reg;
    dlp_pkg::lane_in_t [dlp_pkg::LANES-1:0] lane_next;
    logic                   deg_next;

    assign s_tready = en && (!busy_reg || row_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else if (s_tvalid && s_tready) begin
            busy_reg <= 1'b1;
            row_reg  <= '0;
        end else if (en && busy_reg) begin
            row_reg <= row_reg + 2'd1;
            if (row_reg == 2'd3) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int i = 0; i < 4; i++) begin
                w_reg[i] <= dlp_pkg::weight_t'(
                    s_tdata[i*dlp_pkg::IN_BITS +: dlp_pkg::WB_USE]);
            end
        end
    end

    // stable descending rank: lower index wins ties
    always_comb begin
        rank = '0;
        idx  = '0;
        for (int i = 0; i < 4; i++) begin
            cnt = '0;
            for (int j = 0; j < 4; j++) begin
                if (j < i && w_reg[j] >= w_reg[i]) begin
                    cnt = cnt + 3'd1;
                end else if (j > i && w_reg[j] > w_reg[i]) begin
                    cnt = cnt + 3'd1;
                end
            end
            rank[i] = cnt[1:0];
        end
        for (int i = 0; i < 4; i++) begin
            idx[rank[i]] = 2'(i);
        end
        for (int k = 0; k < 4; k++) begin
            sorted[k] = w_reg[idx[k]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_w_reg   <= sorted;
            p1_idx_reg <= idx;
            p1_pos_reg <= rank[row_reg];
            p1_row_reg <= row_reg;
        end
    end

    assign wa      = dlp_pkg::wide_t'(p1_w_reg[0]);
    assign wb      = dlp_pkg::wide_t'(p1_w_reg[1]);
    assign wc      = dlp_pkg::wide_t'(p1_w_reg[2]);
    assign wd      = dlp_pkg::wide_t'(p1_w_reg[3]);
    assign sum_bcd = wb + wc + wd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_a_reg      <= wa;
            p2_b_reg      <= wb;
            p2_c_reg      <= wc;
            p2_d_reg      <= wd;
            p2_bounce_reg <= wa > sum_bcd;
            p2_abcd_reg   <= wa - sum_bcd;
            p2_pab_reg    <= (wa + wb) - (wc + wd);
            p2_pac_reg    <= (wa + wc) - (wb + wd);
            p2_pbc_reg    <= sum_bcd - wa;
            p2_idx_reg    <= p1_idx_reg;
            p2_pos_reg    <= p1_pos_reg;
            p2_row_reg    <= p1_row_reg;
        end
    end

    always_comb begin
        for (int j = 0; j < dlp_pkg::LANES; j++) begin
            lane_next[j].kind = dlp_pkg::KIND_ZERO;
            lane_next[j].num  = '0;
            lane_next[j].den  = '0;
        end
        deg_next = 1'b0;
        if (p2_bounce_reg) begin
            if (p2_pos_reg == 2'd0) begin
                lane_next[0] = '{dlp_pkg::KIND_DIV, p2_abcd_reg, p2_a_reg};
                lane_next[1] = '{dlp_pkg::KIND_DIV, p2_b_reg, p2_a_reg};
                lane_next[2] = '{dlp_pkg::KIND_DIV, p2_c_reg, p2_a_reg};
                lane_next[3] = '{dlp_pkg::KIND_DIV, p2_d_reg, p2_a_reg};
            end else begin
                lane_next[0].kind = dlp_pkg::KIND_ONE;
            end
        end else begin
            unique case (p2_pos_reg)
                2'd0: begin
                    if (p2_a_reg == '0) begin
                        deg_next = 1'b1;
                    end else begin
                        lane_next[1] = '{dlp_pkg::KIND_DIV, p2_pab_reg, p2_a_reg << 1};
                        lane_next[2] = '{dlp_pkg::KIND_DIV, p2_pac_reg, p2_a_reg << 1};
                        lane_next[3] = '{dlp_pkg::KIND_DIV, p2_d_reg, p2_a_reg};
                    end
                end
                2'd1: begin
                    if (p2_b_reg == '0) begin
                        deg_next = 1'b1;
                    end else begin
                        lane_next[0] = '{dlp_pkg::KIND_DIV, p2_pab_reg, p2_b_reg << 1};
                        lane_next[2] = '{dlp_pkg::KIND_DIV, p2_pbc_reg, p2_b_reg << 1};
                    end
                end
                2'd2: begin
                    if (p2_c_reg == '0) begin
                        deg_next = 1'b1;
                    end else begin
                        lane_next[0] = '{dlp_pkg::KIND_DIV, p2_pac_reg, p2_c_reg << 1};
                        lane_next[1] = '{dlp_pkg::KIND_DIV, p2_pbc_reg, p2_c_reg << 1};
                    end
                end
                default: begin
                    lane_next[0].kind = dlp_pkg::KIND_ONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_lane_reg           <= lane_next;
            p3_meta_reg.row_index <= p2_row_reg;
            p3_meta_reg.col_map   <= p2_idx_reg;
            p3_meta_reg.deg       <= deg_next;
            p3_meta_reg.last      <= p2_row_reg == 2'd3;
        end
    end

    assign row_valid = p3_valid_reg;
    assign row_meta  = p3_meta_reg;
    assign lane_in   = p3_lane_reg;

endmodule

>>> sv/dlp_div_lane.sv
// ---------------------------------------------------------------------------
// dlp_div_lane
// Pipelined restoring fraction divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module dlp_div_lane (
    input  logic              aclk,
    input  logic              en,
    input  dlp_pkg::lane_in_t lane_in,
    output dlp_pkg::prob_t    prob
);

    localparam int NS = dlp_pkg::PROB_FRAC_BITS + 1;

    dlp_pkg::kind_t kind_reg [NS];
    dlp_pkg::wide_t rem_reg  [NS];
    dlp_pkg::wide_t den_reg  [NS];
    logic [dlp_pkg::PROB_FRAC_BITS-1:0] quo_reg [NS];

    logic [dlp_pkg::DW:0] trial [NS-1];
    logic                 take  [NS-1];

    always_comb begin
        for (int k = 0; k < NS - 1; k++) begin
            trial[k] = {rem_reg[k], 1'b0};
            take[k]  = trial[k] >= {1'b0, den_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_reg[0] <= (lane_in.kind == dlp_pkg::KIND_DIV && lane_in.num >= lane_in.den)
                           ? dlp_pkg::KIND_ONE : lane_in.kind;
            rem_reg[0]  <= lane_in.num;
            den_reg[0]  <= lane_in.den;
            quo_reg[0]  <= '0;
            for (int k = 0; k < NS - 1; k++) begin
                kind_reg[k+1] <= kind_reg[k];
                den_reg[k+1]  <= den_reg[k];
                rem_reg[k+1]  <= take[k] ? dlp_pkg::DW'(trial[k] - {1'b0, den_reg[k]})
                                         : trial[k][dlp_pkg::DW-1:0];
                quo_reg[k+1]  <= {quo_reg[k][dlp_pkg::PROB_FRAC_BITS-2:0], take[k]};
            end
        end
    end

    always_comb begin
        unique case (kind_reg[NS-1])
            dlp_pkg::KIND_ONE: prob = dlp_pkg::QW'(1) << dlp_pkg::PROB_FRAC_BITS;
            dlp_pkg::KIND_DIV: prob = {1'b0, quo_reg[NS-1]};
            default:           prob = '0;
        endcase
    end

endmodule

>>> sv/dlp_merge.sv
// ---------------------------------------------------------------------------
// dlp_merge
// Scatter lane results to original columns and hold the output transfer.
// ---------------------------------------------------------------------------
module dlp_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 row_valid,
    input  dlp_pkg::row_meta_t                   row_meta,
    input  dlp_pkg::prob_t [dlp_pkg::LANES-1:0]  lane_prob,
    output logic                                 m_tvalid,
    output logic [dlp_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    logic [dlp_pkg::PROB_W-1:0] col [dlp_pkg::LANES];
    logic                        valid_reg;
    logic [dlp_pkg::M_DATA_W-1:0] data_reg;
    logic                        deg_reg;
    logic                        last_reg;

    always_comb begin
        for (int k = 0; k < dlp_pkg::LANES; k++) begin
            col[k] = '0;
        end
        for (int j = 0; j < dlp_pkg::LANES; j++) begin
            col[row_meta.col_map[j]] = dlp_pkg::PROB_W'(lane_prob[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= row_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= dlp_pkg::M_DATA_W'({col[3], col[2], col[1], col[0],
                                            row_meta.row_index});
            deg_reg  <= row_meta.deg;
            last_reg <= row_meta.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = deg_reg;
    assign m_tlast  = last_reg;

endmodule

>>> sv/directed_loop_probabilities_top.sv
// ---------------------------------------------------------------------------
// directed_loop_probabilities_top
// Minimal-bounce directed-loop transition matrix, four lanes of dividers.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                         | per item
//  s_      | in  | tdata: weight_0..weight_3, 32 bits each         | 1 transfer
//  m_      | out | tdata: row_index, prob_col_0..3; tuser: degen.  | 4 transfers
//
//  The row sequencer issues one row a cycle unless the m_ side stalls, and takes
//  the next item while it issues the last row of the current one.
//  A stalled m_ side freezes the whole pipeline; s_tready drops with it.
//  Reset clears valid bits and the row sequencer state only; no clearing pass.
// ---------------------------------------------------------------------------
`include "directed_loop_probabilities_top_macros.svh"

module directed_loop_probabilities_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // weight_0[31:0], weight_1[63:32], weight_2[95:64], weight_3[127:96]
    input  logic [dlp_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // row_index[1:0], prob_col_0[18:2], prob_col_1[35:19], prob_col_2[52:36],
    // prob_col_3[69:53], zero fill [71:70]
    output logic [dlp_pkg::M_DATA_W-1:0]      m_tdata,
    // degenerate[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int NS = dlp_pkg::PROB_FRAC_BITS + 1;

    logic                                    en;
    logic                                    row_valid;
    dlp_pkg::row_meta_t                      row_meta;
    dlp_pkg::lane_in_t [dlp_pkg::LANES-1:0]  lane_in;
    dlp_pkg::prob_t    [dlp_pkg::LANES-1:0]  lane_prob;

    logic               vline_reg [NS];
    dlp_pkg::row_meta_t mline_reg [NS];

    assign en = !m_tvalid || m_tready;

    dlp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .row_valid (row_valid),
        .row_meta  (row_meta),
        .lane_in   (lane_in)
    );

    for (genvar g = 0; g < dlp_pkg::LANES; g++) begin : g_lane
        dlp_div_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .lane_in (lane_in[g]),
            .prob    (lane_prob[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                vline_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vline_reg[0] <= row_valid;
            for (int k = 0; k < NS - 1; k++) begin
                vline_reg[k+1] <= vline_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mline_reg[0] <= row_meta;
            for (int k = 0; k < NS - 1; k++) begin
                mline_reg[k+1] <= mline_reg[k];
            end
        end
    end

    dlp_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .row_valid (vline_reg[NS-1]),
        .row_meta  (mline_reg[NS-1]),
        .lane_prob (lane_prob),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `DLP_ASSERT_IMP(a_last_is_row3, m_tvalid && m_tlast, m_tdata[1:0] == 2'd3)
    `DLP_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `DLP_ASSERT_NEXT(a_row_follows, m_tvalid && m_tready && !m_tlast && vline_reg[NS-1], m_tvalid)

endmodule

>>> tb/directed_loop_probabilities_top_test.sv
// ----------------------------------------------------------------------------
// directed_loop_probabilities_top_test
// Drives weight quadruples into the directed-loop block and checks every row
// of the transition matrix against an in-bench predictor or a directed table, with random gaps on
// both sides of the stream and a hold-off until the block drains.
// ----------------------------------------------------------------------------
module directed_loop_probabilities_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dlp_pkg::*;

    localparam int  N_RANDOM  = 310;
    localparam int  DRAIN_CYC = PROB_FRAC_BITS + 16;
    localparam int  LIMIT_CYC = 400000;
    localparam logic [QW-1:0] P_ONE = QW'(1) << PROB_FRAC_BITS;

    typedef logic [31:0] w32_t;

    typedef struct {
        logic [1:0]      row;
        logic [QW-1:0]   p [4];
        logic            deg;
        logic            last;
    } row_exp_t;

    typedef struct {
        w32_t            w [4];
        logic            typed;
        logic [QW-1:0]   p [4][4];
        logic            deg [4];
    } vec_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    row_exp_t  rows_due [$];
    int        n_err;
    int        cyc;
    bit        stim_done;
    vec_t      dir_tab [$];

    directed_loop_probabilities_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [QW-1:0] qdiv(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        if (den == 0) return '0;
        if (num >= den) return P_ONE;
        q = ({64'd0, num} << PROB_FRAC_BITS) / den;
        return q[QW-1:0];
    endfunction

    task automatic add_row(input row_exp_t r);
        rows_due = {rows_due, r};
    endtask

    task automatic add_vec(input vec_t v);
        dir_tab = {dir_tab, v};
    endtask

    task automatic predict_matrix(input w32_t win [4]);
        logic [63:0]   w [4];
        logic [63:0]   a, b, c, d, pab, pac, pbc;
        logic [QW-1:0] m [4][4];
        logic          dg [4];
        int            ord [4];
        int            t;
        row_exp_t      r;
        for (int i = 0; i < 4; i++) begin
            w[i] = 64'(win[i]);
            ord[i] = i;
            dg[i] = 1'b0;
            for (int j = 0; j < 4; j++) m[i][j] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 3; j > i; j--)
                if (w[ord[j]] > w[ord[j-1]]) begin
                    t = ord[j]; ord[j] = ord[j-1]; ord[j-1] = t;
                end
        a = w[ord[0]]; b = w[ord[1]]; c = w[ord[2]]; d = w[ord[3]];
        if (a > b + c + d) begin
            m[0][0] = qdiv(a - b - c - d, a);
            m[0][1] = qdiv(b, a);
            m[0][2] = qdiv(c, a);
            m[0][3] = qdiv(d, a);
            m[1][0] = P_ONE; m[2][0] = P_ONE; m[3][0] = P_ONE;
        end else begin
            pab = (a + b) - (c + d);
            pac = (a + c) - (b + d);
            pbc = (b + c + d) - a;
            if (a == 0) dg[0] = 1'b1;
            else begin
                m[0][1] = qdiv(pab, 2 * a);
                m[0][2] = qdiv(pac, 2 * a);
                m[0][3] = qdiv(d, a);
            end
            if (b == 0) dg[1] = 1'b1;
            else begin
                m[1][0] = qdiv(pab, 2 * b);
                m[1][2] = qdiv(pbc, 2 * b);
            end
            if (c == 0) dg[2] = 1'b1;
            else begin
                m[2][0] = qdiv(pac, 2 * c);
                m[2][1] = qdiv(pbc, 2 * c);
            end
            m[3][0] = P_ONE;
        end
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 4; i++)
                if (ord[i] == k) begin
                    r.row = 2'(k);
                    for (int j = 0; j < 4; j++) r.p[ord[j]] = m[i][j];
                    r.deg = dg[i];
                    r.last = (k == 3);
                end
            add_row(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_err++;
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cyc);
    endtask

    function automatic vec_t typed_row(w32_t w0, w32_t w1, w32_t w2, w32_t w3,
                                       logic [QW-1:0] r0 [4], logic [QW-1:0] r1 [4],
                                       logic [QW-1:0] r2 [4], logic [QW-1:0] r3 [4],
                                       logic d0, logic d1, logic d2, logic d3);
        vec_t v;
        v.w = '{w0, w1, w2, w3};
        v.typed = 1'b1;
        v.p[0] = r0; v.p[1] = r1; v.p[2] = r2; v.p[3] = r3;
        v.deg = '{d0, d1, d2, d3};
        return v;
    endfunction

    function automatic vec_t plain_row(w32_t w0, w32_t w1, w32_t w2, w32_t w3);
        vec_t v;
        v.w = '{w0, w1, w2, w3};
        v.typed = 1'b0;
        return v;
    endfunction

    function automatic w32_t rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return w32_t'($urandom_range(0, 15));
            3: return w32_t'($urandom_range(0, 1000));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input w32_t w [4]);
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w[3], w[2], w[1], w[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        logic [QW-1:0] z [4];
        logic [QW-1:0] c0 [4];
        vec_t          v;
        w32_t          w [4];
        logic [31:0]   h;
        row_exp_t      re;
        z  = '{default: '0};
        c0 = '{P_ONE, 0, 0, 0};
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        aresetn   = 1'b0;
        n_err     = 0;
        stim_done = 0;
        // all zero: rows 0..2 degenerate, row 3 exits to 0 with one
        add_vec(typed_row(0, 0, 0, 0, z, z, z, c0, 1'b1, 1'b1, 1'b1, 1'b0));
        // single heavy weight: bounce regime, keeps everything
        add_vec(typed_row(32'hFFFF_FFFF, 0, 0, 0,
            '{P_ONE, 0, 0, 0}, c0, c0, c0, 1'b0, 1'b0, 1'b0, 1'b0));
        add_vec(typed_row(0, 0, 0, 32'd5,
            '{0, 0, 0, P_ONE}, '{0, 0, 0, P_ONE}, '{0, 0, 0, P_ONE},
            '{0, 0, 0, P_ONE}, 1'b0, 1'b0, 1'b0, 1'b0));
        add_vec(plain_row(1, 1, 1, 1));
        add_vec(plain_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF));
        add_vec(plain_row(5, 5, 0, 0));
        add_vec(plain_row(0, 3, 0, 3));
        add_vec(plain_row(7, 3, 4, 0));
        add_vec(plain_row(8, 3, 4, 1));
        add_vec(plain_row(1, 2, 3, 4));
        add_vec(plain_row(4, 3, 2, 1));
        add_vec(plain_row(3, 1, 4, 2));
        add_vec(plain_row(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 0));
        add_vec(plain_row(32'h8000_0000, 32'h5555_5555, 32'h2AAA_AAAA, 1));
        add_vec(plain_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555));
        add_vec(plain_row(2, 2, 2, 0));
        add_vec(plain_row(10, 9, 1, 1));
        add_vec(plain_row(32'd100, 32'd33, 32'd33, 32'd33));
        add_vec(plain_row(32'd100, 32'd33, 32'd33, 32'd34));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir_tab[i]) begin
            v = dir_tab[i];
            if (v.typed) begin
                for (int k = 0; k < 4; k++) begin
                    re = '{2'(k), v.p[k], v.deg[k], k == 3};
                    add_row(re);
                end
            end else begin
                predict_matrix(v.w);
            end
            send_item(v.w);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold the input until every pending row has left
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (rows_due.size() != 0);
            end
            h = $urandom();
            for (int k = 0; k < 4; k++) w[k] = rand_weight();
            if (h[3:0] == 0) begin
                w[$urandom_range(0, 3)] = $urandom() | 32'h8000_0000;
            end else if (h[3:0] == 1) begin
                w[$urandom_range(0, 3)] = w[$urandom_range(0, 3)];
            end
            predict_matrix(w);
            send_item(w);
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if ((cyc / 3000) % 4 == 1) hold = 0;
                m_tready <= (hold == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        row_exp_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (rows_due.size() == 0) begin
                report_mismatch("unexpected row", m_tdata[31:0], 0);
            end else begin
                r = rows_due.pop_front();
                if (m_tdata[1:0] !== r.row) report_mismatch("row_index", m_tdata[1:0], r.row);
                for (int j = 0; j < 4; j++)
                    if (m_tdata[2 + j*PROB_W +: PROB_W] !== r.p[j])
                        report_mismatch($sformatf("row %0d prob_col_%0d", r.row, j),
                                        m_tdata[2 + j*PROB_W +: PROB_W], r.p[j]);
                if (m_tdata[M_DATA_W-1:2+4*PROB_W] !== '0)
                    report_mismatch("fill bits", m_tdata[M_DATA_W-1:2+4*PROB_W], 0);
                if (m_tuser !== r.deg) report_mismatch("degenerate", m_tuser, r.deg);
                if (m_tlast !== r.last) report_mismatch("tlast", m_tlast, r.last);
            end
        end
    end

    initial begin
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc > LIMIT_CYC) begin
                $display("FAILURE");
                $finish;
            end
            if (stim_done && rows_due.size() == 0) begin
                repeat (DRAIN_CYC) @(posedge aclk);
                if (n_err == 0) begin
                    $display("SUCCESS");
                end else begin
                    $display("FAILURE");
                end
                $finish;
            end
        end
    end
endmodule

>>> directed_loop_probabilities_top.f
+incdir+sv
sv/dlp_pkg.sv
sv/dlp_front.sv
sv/dlp_div_lane.sv
sv/dlp_merge.sv
sv/directed_loop_probabilities_top.sv
tb/directed_loop_probabilities_top_test.sv
